// ===== sv/m4xf_pkg.sv =====
// Shared types and constants for the 4x4 Q16.16 transform unit.
// Used by m4xf_ctrl, m4xf_datapath and matrix4_transform_unit.
`default_nettype none

package m4xf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIM       = 4;
  localparam int unsigned NUM_ELEM  = DIM * DIM;
  localparam int unsigned IDX_W     = $clog2(NUM_ELEM);
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CNT_W     = $clog2(NUM_ELEM);
  localparam int unsigned SH_W      = 2 * DATA_W - FRAC_BITS;
  localparam int unsigned SUM_W     = SH_W + 2;

  localparam logic [DATA_W-1:0] IDENT_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] IDENT [NUM_ELEM] = '{
    IDENT_ONE, '0, '0, '0,
    '0, IDENT_ONE, '0, '0,
    '0, '0, IDENT_ONE, '0,
    '0, '0, '0, IDENT_ONE
  };

  typedef enum logic [OP_W-1:0] {
    OP_WR_CUR   = 3'd0,
    OP_WR_RIGHT = 3'd1,
    OP_MUL      = 3'd2,
    OP_TRANSP   = 3'd3,
    OP_XFORM    = 3'd4,
    OP_READ     = 3'd5
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            latch;
    logic            wr_cur;
    logic            wr_right;
    logic            transpose;
    logic            issue;
    logic            use_vec;
    logic            rot_cur;
    logic            rot_right;
    logic            commit;
    logic            load_out;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/m4xf_datapath.sv =====
// Datapath of the transform unit: matrix registers, four multipliers,
// adder with saturation, result shift line and output register. Uses m4xf_pkg.
`default_nettype none

module m4xf_datapath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire m4xf_pkg::cmd_t                cmd_i,
  input  wire        [m4xf_pkg::IDX_W-1:0]   element_index_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  element_value_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_x_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_y_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_z_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_w_i,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_x_o,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_y_o,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_z_o,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_w_o,
  output logic                               overflow_o
);

  localparam int unsigned DW  = m4xf_pkg::DATA_W;
  localparam int unsigned IW  = m4xf_pkg::IDX_W;
  localparam int unsigned N   = m4xf_pkg::NUM_ELEM;
  localparam int unsigned D   = m4xf_pkg::DIM;
  localparam int unsigned SHW = m4xf_pkg::SH_W;
  localparam int unsigned SW  = m4xf_pkg::SUM_W;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic [DW-1:0] cur_q [N];
  logic [DW-1:0] cur_d [N];
  logic [DW-1:0] rgt_q [N];
  logic [DW-1:0] rgt_d [N];
  logic [DW-1:0] res_q [N];
  logic [DW-1:0] res_d [N];

  logic [IW-1:0] idx_q;
  logic [DW-1:0] value_q;
  logic [DW-1:0] vec_q [D];

  logic [DW-1:0]         op_a [D];
  logic [DW-1:0]         op_b [D];
  logic [2*DW-1:0]       prod_full [D];
  logic signed [2*DW-1:0] prod_sh [D];
  logic signed [SHW-1:0] prod_d [D];
  logic signed [SHW-1:0] prod_q [D];
  logic                  prod_v_q;

  logic signed [SW-1:0] sum;
  logic [DW-1:0]        sat_val;
  logic                 sat_flag;
  logic                 ovf_q;

  logic signed [DW-1:0] out_x_d, out_y_d, out_z_d, out_w_d;
  logic                 overflow_d;

  always_comb begin
    cur_d = cur_q;
    priority if (cmd_i.wr_cur) begin
      cur_d[idx_q] = value_q;
    end else if (cmd_i.transpose) begin
      for (int r = 0; r < D; r++) begin
        for (int c = 0; c < D; c++) begin
          cur_d[IW'(r * D + c)] = cur_q[IW'(c * D + r)];
        end
      end
    end else if (cmd_i.rot_cur) begin
      for (int i = 0; i < N; i++) begin
        cur_d[IW'(i)] = cur_q[IW'(i + D)];
      end
    end else if (cmd_i.commit) begin
      cur_d = res_q;
    end
  end

  always_comb begin
    rgt_d = rgt_q;
    priority if (cmd_i.wr_right) begin
      rgt_d[idx_q] = value_q;
    end else if (cmd_i.rot_right) begin
      for (int r = 0; r < D; r++) begin
        for (int c = 0; c < D; c++) begin
          rgt_d[IW'(r * D + c)] = rgt_q[IW'(r * D + ((c + 1) & (D - 1)))];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < D; k++) begin
      op_a[k]      = cur_q[IW'(k)];
      op_b[k]      = cmd_i.use_vec ? vec_q[k] : rgt_q[IW'(k * D)];
      prod_full[k] = {{DW{op_a[k][DW-1]}}, op_a[k]} * {{DW{op_b[k][DW-1]}}, op_b[k]};
      prod_sh[k]   = $signed(prod_full[k]) >>> m4xf_pkg::FRAC_BITS;
      prod_d[k]    = prod_sh[k][SHW-1:0];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < D; k++) begin
      sum = sum + {{(SW-SHW){prod_q[k][SHW-1]}}, prod_q[k]};
    end
    priority if (sum > SAT_HI) begin
      sat_val  = SAT_HI[DW-1:0];
      sat_flag = 1'b1;
    end else if (sum < SAT_LO) begin
      sat_val  = SAT_LO[DW-1:0];
      sat_flag = 1'b1;
    end else begin
      sat_val  = sum[DW-1:0];
      sat_flag = 1'b0;
    end
  end

  always_comb begin
    res_d = res_q;
    if (prod_v_q) begin
      for (int i = 0; i < N - 1; i++) begin
        res_d[IW'(i)] = res_q[IW'(i + 1)];
      end
      res_d[IW'(N - 1)] = sat_val;
    end
  end

  always_comb begin
    out_x_d    = '0;
    out_y_d    = '0;
    out_z_d    = '0;
    out_w_d    = '0;
    overflow_d = 1'b0;
    unique case (cmd_i.op)
      m4xf_pkg::OP_XFORM: begin
        out_x_d    = $signed(res_q[IW'(N - D)]);
        out_y_d    = $signed(res_q[IW'(N - D + 1)]);
        out_z_d    = $signed(res_q[IW'(N - D + 2)]);
        out_w_d    = $signed(res_q[IW'(N - D + 3)]);
        overflow_d = ovf_q;
      end
      m4xf_pkg::OP_MUL: begin
        overflow_d = ovf_q;
      end
      m4xf_pkg::OP_READ: begin
        out_x_d = $signed(cur_q[idx_q]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= m4xf_pkg::IDENT;
      rgt_q    <= m4xf_pkg::IDENT;
      prod_v_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      rgt_q    <= rgt_d;
      prod_v_q <= cmd_i.issue;
      if (cmd_i.latch) begin
        ovf_q <= 1'b0;
      end else if (prod_v_q && sat_flag) begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.issue) begin
      prod_q <= prod_d;
    end
    if (cmd_i.latch) begin
      idx_q    <= element_index_i;
      value_q  <= element_value_i;
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
      vec_q[3] <= vec_w_i;
    end
    if (cmd_i.load_out) begin
      out_x_o    <= out_x_d;
      out_y_o    <= out_y_d;
      out_z_o    <= out_z_d;
      out_w_o    <= out_w_d;
      overflow_o <= overflow_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/m4xf_ctrl.sv =====
// Controller of the transform unit: sequences each item and drives the
// datapath command struct. Uses m4xf_pkg.
`default_nettype none

module m4xf_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [m4xf_pkg::OP_W-1:0]     operation_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output m4xf_pkg::cmd_t               cmd_o
);

  localparam int unsigned CW = m4xf_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIMPLE,
    S_MAC,
    S_DRAIN,
    S_COMMIT,
    S_FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [m4xf_pkg::OP_W-1:0] op_q, op_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  logic                      is_mul, is_xform, last_step;

  assign is_mul      = (op_q == m4xf_pkg::OP_MUL);
  assign is_xform    = (op_q == m4xf_pkg::OP_XFORM);
  assign last_step   = is_mul ? (count_q == CW'(m4xf_pkg::NUM_ELEM - 1))
                              : (count_q == CW'(m4xf_pkg::DIM - 1));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o    = '0;
    cmd_o.op = op_q;
    state_d  = state_q;
    op_d     = op_q;
    count_d  = count_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          op_d    = operation_i;
          count_d = '0;
          priority if (operation_i == m4xf_pkg::OP_WR_CUR ||
                       operation_i == m4xf_pkg::OP_WR_RIGHT ||
                       operation_i == m4xf_pkg::OP_TRANSP) begin
            state_d = S_SIMPLE;
          end else if (operation_i == m4xf_pkg::OP_MUL ||
                       operation_i == m4xf_pkg::OP_XFORM) begin
            state_d = S_MAC;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SIMPLE: begin
        cmd_o.wr_cur    = (op_q == m4xf_pkg::OP_WR_CUR);
        cmd_o.wr_right  = (op_q == m4xf_pkg::OP_WR_RIGHT);
        cmd_o.transpose = (op_q == m4xf_pkg::OP_TRANSP);
        state_d         = S_FINISH;
      end
      S_MAC: begin
        cmd_o.issue     = 1'b1;
        cmd_o.use_vec   = is_xform;
        cmd_o.rot_cur   = is_xform || (count_q[1:0] == 2'b11);
        cmd_o.rot_right = is_mul;
        count_d         = count_q + CW'(1);
        if (last_step) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = is_mul ? S_COMMIT : S_FINISH;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
        if (cmd_o.load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_issue_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.issue && cmd_o.load_out))
    else $error("issue and output load in the same cycle");

  a_mul_enters_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == m4xf_pkg::OP_MUL) |=> (state_q == S_MAC))
    else $error("multiply item did not start the MAC sequence");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while occupied");

  a_xform_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC && is_xform) |-> (count_q < CW'(m4xf_pkg::DIM)))
    else $error("transform step count out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/matrix4_transform_unit.sv =====
// Top level of the 4x4 Q16.16 transform unit: m4xf_ctrl plus m4xf_datapath.
// Depends on m4xf_pkg.
//
// One item runs at a time; in_ready_o is high only between items, while a finished
// result may still wait in the output register. Read and unused codes go straight to
// the output load; writes and transpose first update a matrix. A vector transform runs
// four dot products through the four-multiplier unit, one per cycle, then a drain
// step, the output load and the return to idle; a matrix multiply runs sixteen dot
// products, drain, copy-back into the current matrix, output load and return to
// idle. A stalled output adds its wait. Both matrices reset to identity.
`default_nettype none

module matrix4_transform_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire        [m4xf_pkg::OP_W-1:0]    operation_i,
  input  wire        [m4xf_pkg::IDX_W-1:0]   element_index_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  element_value_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_x_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_y_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_z_i,
  input  wire signed [m4xf_pkg::DATA_W-1:0]  vec_w_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_x_o,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_y_o,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_z_o,
  output logic signed [m4xf_pkg::DATA_W-1:0] out_w_o,
  output logic                               overflow_o
);

  m4xf_pkg::cmd_t cmd;

  m4xf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  m4xf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .vec_x_i         (vec_x_i),
    .vec_y_i         (vec_y_i),
    .vec_z_i         (vec_z_i),
    .vec_w_i         (vec_w_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .out_w_o         (out_w_o),
    .overflow_o      (overflow_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for matrix4_transform_unit: directed and random operation
// sequences, each result checked against a Q16.16 predictor kept in this file.
// Depends on m4xf_pkg and the RTL of the transform unit.

module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1200;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [m4xf_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [m4xf_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam logic signed [m4xf_pkg::DATA_W-1:0] Q_ONE = 32'sh00010000;
  localparam logic signed [m4xf_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [m4xf_pkg::DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [m4xf_pkg::DATA_W-1:0] EDGE_VALS [6] = '{
    32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000,
    32'shFFFFFFFF, 32'sh00010000, 32'shFFFF0000
  };

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [m4xf_pkg::OP_W-1:0]          op;
    logic [m4xf_pkg::IDX_W-1:0]         idx;
    logic signed [m4xf_pkg::DATA_W-1:0] val;
    logic signed [m4xf_pkg::DATA_W-1:0] vx;
    logic signed [m4xf_pkg::DATA_W-1:0] vy;
    logic signed [m4xf_pkg::DATA_W-1:0] vz;
    logic signed [m4xf_pkg::DATA_W-1:0] vw;
  } xform_req_t;

  typedef struct packed {
    logic signed [m4xf_pkg::DATA_W-1:0] x;
    logic signed [m4xf_pkg::DATA_W-1:0] y;
    logic signed [m4xf_pkg::DATA_W-1:0] z;
    logic signed [m4xf_pkg::DATA_W-1:0] w;
    logic                               ovf;
  } xform_res_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               out_ready = 1'b0;
  logic [m4xf_pkg::OP_W-1:0]          op_d = '0;
  logic [m4xf_pkg::IDX_W-1:0]         idx_d = '0;
  logic signed [m4xf_pkg::DATA_W-1:0] val_d = '0;
  logic signed [m4xf_pkg::DATA_W-1:0] vx_d = '0;
  logic signed [m4xf_pkg::DATA_W-1:0] vy_d = '0;
  logic signed [m4xf_pkg::DATA_W-1:0] vz_d = '0;
  logic signed [m4xf_pkg::DATA_W-1:0] vw_d = '0;
  wire                                in_ready_o;
  wire                                out_valid_o;
  wire signed [m4xf_pkg::DATA_W-1:0]  out_x_o;
  wire signed [m4xf_pkg::DATA_W-1:0]  out_y_o;
  wire signed [m4xf_pkg::DATA_W-1:0]  out_z_o;
  wire signed [m4xf_pkg::DATA_W-1:0]  out_w_o;
  wire                                overflow_o;

  logic signed [m4xf_pkg::DATA_W-1:0] cur_m [m4xf_pkg::NUM_ELEM];
  logic signed [m4xf_pkg::DATA_W-1:0] rhs_m [m4xf_pkg::NUM_ELEM];
  xform_res_t                         awaited_outputs [$];
  int                                 mismatch_count = 0;
  int                                 cycle_count = 0;
  int                                 burst_left = 1;
  int                                 random_count = 0;
  rx_mode_e                           rx_mode = RX_OPEN;
  int                                 rx_left = 0;
  logic [3:0]                         rx_phase = '0;

  matrix4_transform_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .operation_i     (op_d),
    .element_index_i (idx_d),
    .element_value_i (val_d),
    .vec_x_i         (vx_d),
    .vec_y_i         (vy_d),
    .vec_z_i         (vz_d),
    .vec_w_i         (vw_d),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .out_w_o         (out_w_o),
    .overflow_o      (overflow_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint scaled_product(logic signed [m4xf_pkg::DATA_W-1:0] a,
                                            logic signed [m4xf_pkg::DATA_W-1:0] b);
    return (longint'(a) * longint'(b)) >>> m4xf_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [m4xf_pkg::DATA_W-1:0] clamp_sum(longint s,
                                                                   inout logic ovf);
    if (s > S32_MAX) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (s < S32_MIN) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return s[m4xf_pkg::DATA_W-1:0];
  endfunction

  function automatic xform_res_t apply_op(xform_req_t r);
    xform_res_t                         res;
    logic signed [m4xf_pkg::DATA_W-1:0] tmp_m [m4xf_pkg::NUM_ELEM];
    logic signed [m4xf_pkg::DATA_W-1:0] vec [m4xf_pkg::DIM];
    logic signed [m4xf_pkg::DATA_W-1:0] lane [m4xf_pkg::DIM];
    logic                               ovf;
    longint                             acc;
    res = '0;
    ovf = 1'b0;
    vec = '{r.vx, r.vy, r.vz, r.vw};
    lane = '{default: '0};
    case (r.op)
      m4xf_pkg::OP_WR_CUR: cur_m[r.idx] = r.val;
      m4xf_pkg::OP_WR_RIGHT: rhs_m[r.idx] = r.val;
      m4xf_pkg::OP_MUL: begin
        for (int i = 0; i < m4xf_pkg::DIM; i++) begin
          for (int j = 0; j < m4xf_pkg::DIM; j++) begin
            acc = 0;
            for (int k = 0; k < m4xf_pkg::DIM; k++) begin
              acc += scaled_product(cur_m[i*m4xf_pkg::DIM+k], rhs_m[k*m4xf_pkg::DIM+j]);
            end
            tmp_m[i*m4xf_pkg::DIM+j] = clamp_sum(acc, ovf);
          end
        end
        cur_m = tmp_m;
      end
      m4xf_pkg::OP_TRANSP: begin
        for (int i = 0; i < m4xf_pkg::DIM; i++) begin
          for (int j = 0; j < m4xf_pkg::DIM; j++) begin
            tmp_m[i*m4xf_pkg::DIM+j] = cur_m[j*m4xf_pkg::DIM+i];
          end
        end
        cur_m = tmp_m;
      end
      m4xf_pkg::OP_XFORM: begin
        for (int i = 0; i < m4xf_pkg::DIM; i++) begin
          acc = 0;
          for (int j = 0; j < m4xf_pkg::DIM; j++) begin
            acc += scaled_product(cur_m[i*m4xf_pkg::DIM+j], vec[j]);
          end
          lane[i] = clamp_sum(acc, ovf);
        end
      end
      m4xf_pkg::OP_READ: lane[0] = cur_m[r.idx];
      default: ;
    endcase
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    res.w = lane[3];
    res.ovf = ovf;
    return res;
  endfunction

  function automatic logic signed [m4xf_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
      4: return EDGE_VALS[$urandom_range(0, 5)];
      5: return (int'($urandom_range(0, 15)) - 8) * 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [m4xf_pkg::DATA_W-1:0] got,
                                 input logic [m4xf_pkg::DATA_W-1:0] want);
    if (mismatch_count < 50)
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [m4xf_pkg::OP_W-1:0] op,
                           input logic [m4xf_pkg::IDX_W-1:0] idx,
                           input logic signed [m4xf_pkg::DATA_W-1:0] val,
                           input logic signed [m4xf_pkg::DATA_W-1:0] vx,
                           input logic signed [m4xf_pkg::DATA_W-1:0] vy,
                           input logic signed [m4xf_pkg::DATA_W-1:0] vz,
                           input logic signed [m4xf_pkg::DATA_W-1:0] vw);
    xform_req_t req;
    req = '{op, idx, val, vx, vy, vz, vw};
    in_valid <= 1'b1;
    op_d <= op;
    idx_d <= idx;
    val_d <= val;
    vx_d <= vx;
    vy_d <= vy;
    vz_d <= vz;
    vw_d <= vw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_outputs.push_back(apply_op(req));
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
    end
  endtask

  task automatic send_random(input logic [m4xf_pkg::OP_W-1:0] op);
    send_item(op, (m4xf_pkg::IDX_W)'($urandom_range(0, m4xf_pkg::NUM_ELEM - 1)),
              pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
    if (op <= m4xf_pkg::OP_READ)
      random_count++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_small_matrix(input logic [m4xf_pkg::OP_W-1:0] op);
    for (int i = 0; i < m4xf_pkg::NUM_ELEM; i++) begin
      send_item(op, (m4xf_pkg::IDX_W)'(i), int'($urandom_range(0, 32'h40000)) - 32'sh20000,
                $urandom, $urandom, $urandom, $urandom);
      random_count++;
    end
  endtask

  task automatic test_reset_state();
    send_item(m4xf_pkg::OP_READ, 4'd0, $urandom, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd5, $urandom, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd15, $urandom, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_XFORM, 4'd0, 0, Q_ONE, -32'sh20000, Q_MAX, Q_MIN);
  endtask

  task automatic test_element_access();
    send_item(m4xf_pkg::OP_WR_CUR, 4'd0, Q_MAX, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_WR_CUR, 4'd15, Q_MIN, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd0, 0, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd15, 0, 0, 0, 0, 0);
  endtask

  task automatic test_transpose();
    send_item(m4xf_pkg::OP_WR_CUR, 4'd1, 32'sh00012345, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_TRANSP, 4'd0, 0, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd4, 0, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd1, 0, 0, 0, 0, 0);
  endtask

  task automatic test_saturation();
    send_item(m4xf_pkg::OP_XFORM, 4'd0, 0, Q_MAX, 0, 0, Q_MIN);
    send_item(m4xf_pkg::OP_XFORM, 4'd0, 0, Q_MIN, Q_ONE, Q_ONE, Q_MAX);
    send_item(m4xf_pkg::OP_WR_RIGHT, 4'd0, Q_MIN, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_MUL, 4'd0, 0, 0, 0, 0, 0);
    send_item(m4xf_pkg::OP_READ, 4'd0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_unused_codes();
    send_item(OP_SPARE_6, 4'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(OP_SPARE_7, 4'd12, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_sequences();
    logic drained_mid;
    drained_mid = 1'b0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0)
        load_small_matrix(($urandom_range(0, 1) == 0) ? m4xf_pkg::OP_WR_CUR
                                                      : m4xf_pkg::OP_WR_RIGHT);
      repeat ($urandom_range(1, 8))
        send_random(($urandom_range(0, 2) == 0) ? m4xf_pkg::OP_WR_RIGHT
                                                : m4xf_pkg::OP_WR_CUR);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1: send_random(m4xf_pkg::OP_MUL);
          2: send_random(m4xf_pkg::OP_TRANSP);
          3, 4, 5, 6: send_random(m4xf_pkg::OP_XFORM);
          default: send_random(m4xf_pkg::OP_READ);
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) send_random((m4xf_pkg::OP_W)'($urandom_range(0, 7)));
      if (!drained_mid && random_count >= RANDOM_ITEMS / 2) begin
        wait_drain();
        drained_mid = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 4'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rx_phase[2];
    endcase
  end

  always @(posedge clk_i) begin : check_results
    xform_res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (awaited_outputs.size() == 0) begin
        report_mismatch("result with nothing pending", out_x_o, '0);
      end else begin
        want = awaited_outputs.pop_front();
        if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
        if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
        if (out_z_o !== want.z) report_mismatch("out_z", out_z_o, want.z);
        if (out_w_o !== want.w) report_mismatch("out_w", out_w_o, want.w);
        if (overflow_o !== want.ovf) report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL matrix4_transform_unit");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < m4xf_pkg::NUM_ELEM; i++) begin
      cur_m[i] = m4xf_pkg::IDENT[i];
      rhs_m[i] = m4xf_pkg::IDENT[i];
    end
    burst_left = $urandom_range(1, 12);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_element_access();
    test_transpose();
    test_saturation();
    test_unused_codes();
    wait_drain();
    test_random_sequences();
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_outputs.size() == 0)
      $display("PASS matrix4_transform_unit");
    else
      $display("FAIL matrix4_transform_unit");
    $finish;
  end

endmodule
